FILE: rtl/core/tlvd_pkg.sv
`timescale 1ns / 1ps

package tlvd_pkg;

    // Number of bytes that follow the long-length mark (1 to 4)
    localparam int EXT_LEN_BYTES = 4;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [7:0] LONG_MARK = 8'hFF;

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;

    typedef enum logic [3:0] {
        PH_TAG = 4'b0001,
        PH_LEN = 4'b0010,
        PH_EXT = 4'b0100,
        PH_VAL = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  element_tag;
        logic [7:0]  value_byte;
        logic [31:0] value_offset;
        logic        element_last;
        logic        truncated;
        logic        buffer_done;
    } out_item_t;

endpackage

FILE: rtl/core/tlvd_front.sv
`timescale 1ns / 1ps

module tlvd_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tlvd_pkg::in_item_t  in_item,
    input  logic                take,
    output logic                res_valid,
    output tlvd_pkg::out_item_t res_item
);

    tlvd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       tag_reg, tag_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      pos_reg, pos_next;
    logic [1:0]       cnt_reg, cnt_next;

    logic [7:0]  b;
    logic        eob;
    logic [31:0] ext_lane;
    logic [31:0] rem_dec;
    logic        known;
    logic [31:0] known_len;
    logic        hdr_end;

    assign b   = in_item.data_byte;
    assign eob = in_item.end_of_buffer;
    assign rem_dec = rem_reg - 32'd1;

    always_comb
    begin
        case (cnt_reg)
            2'd0:    ext_lane = {24'd0, b};
            2'd1:    ext_lane = {16'd0, b, 8'd0};
            2'd2:    ext_lane = {8'd0, b, 16'd0};
            default: ext_lane = {b, 24'd0};
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        known      = 1'b0;
        known_len  = 32'd0;
        hdr_end    = 1'b0;
        res_valid  = 1'b0;
        res_item   = '0;

        unique case (phase_reg)
            tlvd_pkg::PH_LEN:
            begin
                if (b != tlvd_pkg::LONG_MARK)
                begin
                    known     = 1'b1;
                    known_len = {24'd0, b};
                end
                else
                begin
                    rem_next   = 32'd0;
                    cnt_next   = 2'd0;
                    phase_next = tlvd_pkg::PH_EXT;
                    hdr_end    = 1'b1;
                end
            end
            tlvd_pkg::PH_EXT:
            begin
                if (({1'b0, cnt_reg} + 3'd1) >= 3'(tlvd_pkg::EXT_LEN_BYTES))
                begin
                    cnt_next  = 2'd0;
                    known     = 1'b1;
                    known_len = rem_reg | ext_lane;
                end
                else
                begin
                    rem_next = rem_reg | ext_lane;
                    cnt_next = cnt_reg + 2'd1;
                    hdr_end  = 1'b1;
                end
            end
            tlvd_pkg::PH_VAL:
            begin
                pos_next = pos_reg + 32'd1;
                rem_next = rem_dec;
                if ((rem_dec == 32'd0) || eob)
                    phase_next = tlvd_pkg::PH_TAG;
                res_valid             = 1'b1;
                res_item.kind         = tlvd_pkg::KIND_VALUE;
                res_item.value_byte   = b;
                res_item.value_offset = pos_reg;
                res_item.element_last = (rem_dec == 32'd0);
                res_item.truncated    = eob && (rem_dec != 32'd0);
                res_item.buffer_done  = eob;
            end
            tlvd_pkg::PH_TAG:
            begin
                tag_next   = b;
                phase_next = tlvd_pkg::PH_LEN;
                hdr_end    = 1'b1;
            end
            default:
            begin
                // unreachable encodings behave as the tag phase
                tag_next   = b;
                phase_next = tlvd_pkg::PH_LEN;
                hdr_end    = 1'b1;
            end
        endcase

        if (known)
        begin
            rem_next = known_len;
            pos_next = 32'd0;
            if (known_len == 32'd0)
            begin
                phase_next            = tlvd_pkg::PH_TAG;
                res_valid             = 1'b1;
                res_item.kind         = tlvd_pkg::KIND_EMPTY;
                res_item.element_last = 1'b1;
                res_item.buffer_done  = eob;
            end
            else
            begin
                phase_next = tlvd_pkg::PH_VAL;
                hdr_end    = 1'b1;
            end
        end

        // buffer ended inside the header: flag truncation, back to tag
        if (hdr_end && eob)
        begin
            phase_next           = tlvd_pkg::PH_TAG;
            res_valid            = 1'b1;
            res_item.kind        = tlvd_pkg::KIND_TRUNC;
            res_item.truncated   = 1'b1;
            res_item.buffer_done = 1'b1;
        end

        res_item.element_tag = tag_next;
        res_valid = res_valid && in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tlvd_pkg::PH_TAG;
            tag_reg   <= 8'd0;
            rem_reg   <= 32'd0;
            pos_reg   <= 32'd0;
            cnt_reg   <= 2'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: rtl/core/tlvd_queue.sv
`timescale 1ns / 1ps

module tlvd_queue
#(
    parameter int DEPTH = tlvd_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlvd_pkg::out_item_t push_item,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output tlvd_pkg::out_item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tlvd_pkg::out_item_t slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/core/tlvd_back.sv
`timescale 1ns / 1ps

module tlvd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tlvd_pkg::out_item_t q_item,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output tlvd_pkg::out_item_t out_item
);

    logic                valid_reg;
    tlvd_pkg::out_item_t item_reg, item_next;
    logic                load;

    assign load  = !valid_reg || out_ready;
    assign q_pop = load && q_valid;

    // only value items carry a byte and an offset
    always_comb
    begin
        item_next = q_item;
        if (q_item.kind != tlvd_pkg::KIND_VALUE)
        begin
            item_next.value_byte   = 8'd0;
            item_next.value_offset = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: rtl/core/tlv_stream_deframer.sv
`timescale 1ns / 1ps
// A result is registered in the queue by the edge that accepts its byte, and
// moves to the output register once that register is empty or being read.
// Throughput: one byte per cycle while the queue has room, set by the front
// phase register update; header bytes that complete nothing are taken but give no item.
// Reset (rst_n low, asynchronous) returns the parser to the tag phase,
// clears length and offset state, and empties the queue and output stage.

module tlv_stream_deframer
#(
    parameter int QUEUE_DEPTH = tlvd_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tlvd_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output tlvd_pkg::out_item_t out_item
);

    logic                res_valid;
    tlvd_pkg::out_item_t res_item;
    logic                q_ready;
    logic                q_valid;
    logic                q_pop;
    tlvd_pkg::out_item_t q_item;

    assign in_ready = q_ready;

    tlvd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .take      (in_valid && q_ready),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    tlvd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_item  (res_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (q_item)
    );

    tlvd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

FILE: rtl/core/tlvd_checker.sv
`timescale 1ns / 1ps

module tlvd_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input tlvd_pkg::out_item_t out_item
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.truncated |-> out_item.buffer_done && !out_item.element_last)
        else $error("truncation outside buffer end");

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == tlvd_pkg::KIND_EMPTY) |->
            out_item.element_last && !out_item.truncated &&
            (out_item.value_byte == 8'd0) && (out_item.value_offset == 32'd0))
        else $error("malformed empty element item");

    a_trunc_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == tlvd_pkg::KIND_TRUNC) |->
            out_item.truncated && (out_item.value_byte == 8'd0) &&
            (out_item.value_offset == 32'd0))
        else $error("malformed truncation item");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.kind == tlvd_pkg::KIND_VALUE) ||
            (out_item.kind == tlvd_pkg::KIND_EMPTY) ||
            (out_item.kind == tlvd_pkg::KIND_TRUNC))
        else $error("illegal item kind");

endmodule

bind tlv_stream_deframer tlvd_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
